FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk, held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DDO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ddo_pkg.sv
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned CORDIC_MAX       = 32;

  localparam logic [31:0] RADIUS_RST   = 32'd6554;
  localparam logic [31:0] SEP_RST      = 32'd32768;
  localparam logic [31:0] INV_TWO_PI   = 32'd683565276;
  localparam logic [33:0] CORDIC_GAIN  = 34'd652032874;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_SEP    = 1'b1;

  typedef logic [32:0] mul_op_t;
  typedef logic [65:0] mul_res_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] t;
    unique case (idx)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // Signed saturation of a sign and magnitude to 32 bits.
  function automatic logic [31:0] sat32(input logic neg, input logic [64:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag > 65'h80000000) ? 32'h80000000 : (32'd0 - mag[31:0]);
    end else begin
      r = (mag > 65'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

FILE: hw/rtl/diff_drive_odometry.sv
// The 65-step restoring divider for angular velocity dominates the time
// from input transaction to result valid.
// Only one transaction is in flight at a time;
// in_stall stays high from acceptance until the result is taken.
// Reset (synchronous, rst_n low): pose and heading clear to zero, wheel
// radius and separation return to their defaults, no result is pending.
module diff_drive_odometry
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_left_rate,
  input  logic [31:0] in_right_rate,
  input  logic [31:0] in_elapsed_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_pose_x,
  output logic [47:0] out_pose_y,
  output logic [31:0] out_heading,
  output logic [31:0] out_linear_velocity,
  output logic [31:0] out_angular_velocity
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MV   = 4'd1;
  localparam logic [3:0] S_MW   = 4'd2;
  localparam logic [3:0] S_DST  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_MX1  = 4'd5;
  localparam logic [3:0] S_MX2  = 4'd6;
  localparam logic [3:0] S_MY1  = 4'd7;
  localparam logic [3:0] S_MY2  = 4'd8;
  localparam logic [3:0] S_MH1  = 4'd9;
  localparam logic [3:0] S_MH2  = 4'd10;
  localparam logic [3:0] S_MH3  = 4'd11;
  localparam logic [3:0] S_UPD  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic signed [51:0] POS_MAX = 52'sh00007FFFFFFFFFFF;
  localparam logic signed [51:0] POS_MIN = -52'sh0000800000000000;

  logic [3:0]  state_r;
  logic [31:0] radius_r, sep_r, dt_r;
  logic        sum_neg_r, diff_neg_r, pw_zero_r, out_valid_r;
  logic [32:0] sum_mag_r, diff_mag_r;
  logic [31:0] v_r, w_r, head_r, p_hi_r;
  logic [63:0] a_r;
  logic signed [50:0] dx_r, dy_r;
  logic signed [47:0] pos_x_r, pos_y_r;

  logic signed [32:0] sum, diff;
  logic        in_acc;
  mul_op_t     op_a, op_b;
  mul_res_t    prod;
  logic [64:0] quo;
  logic        div_done, cor_done, div_start;
  logic [33:0] cos_v, sin_v, cmag, smag;
  logic [31:0] vmag, wmag;
  logic [49:0] dmag;
  logic [95:0] hsum;
  logic [31:0] dh;
  logic signed [51:0] nx, ny;

  assign in_acc    = in_valid && !in_stall;
  assign sum       = {in_left_rate[31], in_left_rate} + {in_right_rate[31], in_right_rate};
  assign diff      = {in_right_rate[31], in_right_rate} - {in_left_rate[31], in_left_rate};
  assign vmag      = abs32(v_r);
  assign wmag      = abs32(w_r);
  assign cmag      = cos_v[33] ? (34'd0 - cos_v) : cos_v;
  assign smag      = sin_v[33] ? (34'd0 - sin_v) : sin_v;
  assign dmag      = prod[65:16];
  assign div_start = (state_r == S_DST);

  ddo_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[64:0]),
    .divisor  (sep_r),
    .quotient (quo),
    .done     (div_done)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .angle   (head_r),
    .cos_out (cos_v),
    .sin_out (sin_v),
    .done    (cor_done)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_MV:  begin op_a = {1'b0, radius_r}; op_b = sum_mag_r;  end
      S_MW:  begin op_a = {1'b0, radius_r}; op_b = diff_mag_r; end
      S_MX1: begin op_a = {1'b0, vmag};     op_b = cmag[32:0]; end
      S_MX2: begin op_a = prod[62:30];      op_b = {1'b0, dt_r}; end
      S_MY1: begin op_a = {1'b0, vmag};     op_b = smag[32:0]; end
      S_MY2: begin op_a = prod[62:30];      op_b = {1'b0, dt_r}; end
      S_MH1: begin op_a = {1'b0, wmag};     op_b = {1'b0, dt_r}; end
      S_MH2: begin op_a = {1'b0, prod[31:0]}; op_b = {1'b0, INV_TWO_PI}; end
      S_MH3: begin op_a = {1'b0, p_hi_r};   op_b = {1'b0, INV_TWO_PI}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // heading step: bits 71..40 of |w|*dt*K
  assign hsum = {32'd0, a_r} + {prod[63:0], 32'd0};
  assign dh   = w_r[31] ? (32'd0 - hsum[71:40]) : hsum[71:40];
  assign nx   = {{4{pos_x_r[47]}}, pos_x_r} + {dx_r[50], dx_r};
  assign ny   = {{4{pos_y_r[47]}}, pos_y_r} + {dy_r[50], dy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      radius_r    <= RADIUS_RST;
      sep_r       <= SEP_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RADIUS: radius_r <= cfg_wdata;
          CFG_SEP:    sep_r    <= cfg_wdata;
          default:    radius_r <= radius_r;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_acc) state_r <= S_MV;
        S_MV:   state_r <= S_MW;
        S_MW:   state_r <= S_DST;
        S_DST:  state_r <= S_DIV;
        S_DIV:  if (div_done && cor_done) state_r <= S_MX1;
        S_MX1:  state_r <= S_MX2;
        S_MX2:  state_r <= S_MY1;
        S_MY1:  state_r <= S_MY2;
        S_MY2:  state_r <= S_MH1;
        S_MH1:  state_r <= S_MH2;
        S_MH2:  state_r <= S_MH3;
        S_MH3:  state_r <= S_UPD;
        S_UPD: begin
          pos_x_r     <= (nx > POS_MAX) ? POS_MAX[47:0] : ((nx < POS_MIN) ? POS_MIN[47:0] : nx[47:0]);
          pos_y_r     <= (ny > POS_MAX) ? POS_MAX[47:0] : ((ny < POS_MIN) ? POS_MIN[47:0] : ny[47:0]);
          head_r      <= head_r + dh;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          // hold the result until the transaction completes
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r       <= in_elapsed_time;
      sum_neg_r  <= sum[32];
      sum_mag_r  <= sum[32] ? (33'd0 - sum) : sum;
      diff_neg_r <= diff[32];
      diff_mag_r <= diff[32] ? (33'd0 - diff) : diff;
    end
    unique case (state_r)
      S_MW:  v_r <= sat32(sum_neg_r, {16'd0, prod[65:17]});
      S_DST: pw_zero_r <= (prod == '0);
      S_DIV: w_r <= sat32(diff_neg_r, pw_zero_r ? 65'd0 : quo);
      S_MY1: dx_r <= (v_r[31] ^ cos_v[33]) ? (51'sd0 - {1'b0, dmag}) : {1'b0, dmag};
      S_MH1: dy_r <= (v_r[31] ^ sin_v[33]) ? (51'sd0 - {1'b0, dmag}) : {1'b0, dmag};
      S_MH2: p_hi_r <= prod[63:32];
      S_MH3: a_r <= prod[63:0];
      default: a_r <= a_r;
    endcase
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_pose_x           = pos_x_r;
  assign out_pose_y           = pos_y_r;
  assign out_heading          = head_r;
  assign out_linear_velocity  = v_r;
  assign out_angular_velocity = w_r;

endmodule

FILE: hw/rtl/ddo_mul.sv
module ddo_mul
  import ddo_pkg::*;
(
  input  logic     clk,
  input  mul_op_t  op_a,
  input  mul_op_t  op_b,
  output mul_res_t prod
);

  mul_res_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {33'd0, op_a} * {33'd0, op_b};
  end

  assign prod = prod_r;

endmodule

FILE: hw/rtl/ddo_div.sv
module ddo_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] dividend,
  input  logic [31:0] divisor,
  output logic [64:0] quotient,
  output logic        done
);

  logic [64:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [33:0] trial;

  assign shifted = {rem_r, quo_r[64]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'd64) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= 32'd0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[63:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        quo_r <= {quo_r[63:0], 1'b0};
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: hw/rtl/ddo_cordic.sv
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] angle,
  output logic [33:0] cos_out,
  output logic [33:0] sin_out,
  output logic        done
);

  localparam int unsigned NSTEP = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;

  logic signed [33:0] x_r, y_r, z_r;
  logic [5:0]         i_r;
  logic               busy_r, done_r, flip_r;
  logic signed [33:0] z_in, z_alt, xs, ys;
  logic [31:0]        alt_ang;

  assign z_in    = {{2{angle[31]}}, angle};
  assign alt_ang = angle + 32'h80000000;
  assign z_alt   = {{2{alt_ang[31]}}, alt_ang};
  assign xs      = x_r >>> i_r[4:0];
  assign ys      = y_r >>> i_r[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      i_r    <= 6'd0;
    end else if (busy_r) begin
      if (i_r == 6'(NSTEP)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        i_r <= i_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_GAIN;
      y_r <= 34'sd0;
      // fold into the right half-plane, undo with a sign flip at the end
      if (z_in > 34'sh40000000 || z_in < -34'sh40000000) begin
        z_r    <= z_alt;
        flip_r <= 1'b1;
      end else begin
        z_r    <= z_in;
        flip_r <= 1'b0;
      end
    end else if (busy_r && i_r != 6'(NSTEP)) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - {2'b00, atan_turn(i_r[4:0])};
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + {2'b00, atan_turn(i_r[4:0])};
      end
    end
  end

  assign cos_out = flip_r ? (34'd0 - x_r) : x_r;
  assign sin_out = flip_r ? (34'd0 - y_r) : y_r;
  assign done    = done_r;

endmodule

FILE: hw/rtl/ddo_checker.sv
`include "assert_macros.svh"

module ddo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_pose_x,
  input logic [31:0] out_heading
);

  `DDO_ASSERT_NOW(a_no_take_while_pending, in_valid && !in_stall, !out_valid, "input taken while result pending")
  `DDO_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall && !out_valid, "not busy after input transaction")
  `DDO_ASSERT_NEXT(a_drop_after_out, out_valid && !out_stall, !out_valid, "result repeated")
  `DDO_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_pose_x) && $stable(out_heading), "stalled result changed")

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

FILE: tb/diff_drive_odometry_tb.sv
`timescale 1ns / 1ps

module diff_drive_odometry_tb;
  import ddo_pkg::*;

  localparam int ROTATION_STEPS = 24;
  localparam longint unsigned TURN_SCALE = 64'd683565276;
  localparam longint START_GAIN = 64'd652032874;
  localparam longint POSE_MAX = 64'sh7FFFFFFFFFFF;
  localparam longint POSE_MIN = -64'sh800000000000;
  localparam bit [31:0] TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  typedef struct {
    bit [47:0] x;
    bit [47:0] y;
    bit [31:0] hdg;
    bit [31:0] lin;
    bit [31:0] ang;
  } odo_pose_t;

  class odo_scoreboard;
    bit [31:0] radius;
    bit [31:0] separation;
    longint pos_x;
    longint pos_y;
    bit [31:0] hdg;
    odo_pose_t pending[$];
    int errors;

    function void clear();
      radius = RADIUS_RST;
      separation = SEP_RST;
      pos_x = 0;
      pos_y = 0;
      hdg = 0;
      pending.delete();
    endfunction

    function void set_reg(logic idx, bit [31:0] d);
      if (idx == CFG_RADIUS) radius = d;
      else separation = d;
    endfunction

    function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint clamp32(bit neg, longint unsigned m);
      if (neg) return (m > 64'h80000000) ? -64'sh80000000 : -longint'(m);
      return (m > 64'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(m);
    endfunction

    function longint travel(longint v, longint t, bit [31:0] dt);
      longint unsigned m, d;
      m = (mag(v) * mag(t)) >> 30;
      d = (m * {32'd0, dt}) >> 16;
      return ((v < 0) != (t < 0)) ? -longint'(d) : longint'(d);
    endfunction

    function longint clamp_pose(longint p);
      return (p > POSE_MAX) ? POSE_MAX : ((p < POSE_MIN) ? POSE_MIN : p);
    endfunction

    function void note(bit [31:0] l, bit [31:0] r, bit [31:0] dt);
      longint sum, diff, v, w, cx, cy, z, xs, ys;
      longint unsigned pv, pw, p;
      bit [95:0] prod;
      bit [31:0] dh;
      bit flip;
      odo_pose_t e;
      sum = longint'($signed(l)) + longint'($signed(r));
      diff = longint'($signed(r)) - longint'($signed(l));
      pv = {32'd0, radius} * mag(sum);
      pw = {32'd0, radius} * mag(diff);
      v = clamp32(sum < 0, pv >> 17);
      if (separation == 0) w = clamp32(diff < 0, (pw == 0) ? 64'd0 : '1);
      else w = clamp32(diff < 0, pw / {32'd0, separation});
      // fold the heading into the right half-plane, negate afterwards
      z = longint'($signed(hdg));
      flip = 0;
      if (z > 64'sh40000000 || z < -64'sh40000000) begin
        z = longint'($signed(hdg + 32'h80000000));
        flip = 1;
      end
      cx = START_GAIN;
      cy = 0;
      for (int i = 0; i < ROTATION_STEPS && i < 32; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (z >= 0) begin
          cx -= ys; cy += xs; z -= longint'(TURNS[i]);
        end else begin
          cx += ys; cy -= xs; z += longint'(TURNS[i]);
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      pos_x = clamp_pose(pos_x + travel(v, cx, dt));
      pos_y = clamp_pose(pos_y + travel(v, cy, dt));
      p = mag(w) * {32'd0, dt};
      prod = {32'd0, p} * {32'd0, TURN_SCALE};
      dh = prod[71:40];
      if (w < 0) dh = -dh;
      hdg += dh;
      e.x = pos_x[47:0];
      e.y = pos_y[47:0];
      e.hdg = hdg;
      e.lin = v[31:0];
      e.ang = w[31:0];
      pending.push_back(e);
    endfunction

    function void check(odo_pose_t got);
      odo_pose_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x != e.x) begin
        $error("pose_x expected %h got %h", e.x, got.x); errors++;
      end
      if (got.y != e.y) begin
        $error("pose_y expected %h got %h", e.y, got.y); errors++;
      end
      if (got.hdg != e.hdg) begin
        $error("heading expected %h got %h", e.hdg, got.hdg); errors++;
      end
      if (got.lin != e.lin) begin
        $error("linear_velocity expected %h got %h", e.lin, got.lin); errors++;
      end
      if (got.ang != e.ang) begin
        $error("angular_velocity expected %h got %h", e.ang, got.ang); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_index = CFG_RADIUS;
  logic [31:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] in_left_rate = 0;
  logic [31:0] in_right_rate = 0;
  logic [31:0] in_elapsed_time = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [47:0] out_pose_x, out_pose_y;
  logic [31:0] out_heading, out_linear_velocity, out_angular_velocity;

  odo_scoreboard odo_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #10 clk = ~clk;

  diff_drive_odometry DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_rate(in_left_rate), .in_right_rate(in_right_rate),
    .in_elapsed_time(in_elapsed_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pose_x(out_pose_x), .out_pose_y(out_pose_y), .out_heading(out_heading),
    .out_linear_velocity(out_linear_velocity),
    .out_angular_velocity(out_angular_velocity)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 700;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    odo_pose_t got;
    if (rst_n && in_valid && !in_stall)
      odo_sb.note(in_left_rate, in_right_rate, in_elapsed_time);
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_pose_x;
      got.y = out_pose_y;
      got.hdg = out_heading;
      got.lin = out_linear_velocity;
      got.ang = out_angular_velocity;
      odo_sb.check(got);
    end
  end

  task automatic send_motion(bit [31:0] l, bit [31:0] r, bit [31:0] dt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_left_rate <= l;
    in_right_rate <= r;
    in_elapsed_time <= dt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (odo_sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [31:0] d);
    drain_results();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 0;
    odo_sb.set_reg(idx, d);
  endtask

  function automatic bit [31:0] pick_rate();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000);
    endcase
  endfunction

  function automatic bit [31:0] pick_dt();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
      default: return $urandom_range(0, 32'h01000000);
    endcase
  endfunction

  task automatic run_phase(int n);
    bit [31:0] l;
    for (int i = 0; i < n; i++) begin
      l = pick_rate();
      // hold both wheels near each other now and then for straight runs
      if ($urandom_range(3) == 0) send_motion(l, l + $urandom_range(0, 255), pick_dt());
      else send_motion(l, pick_rate(), pick_dt());
    end
  endtask

  initial begin
    odo_sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part, starting at the reset settings
    send_motion(32'h0, 32'h0, 32'h0);
    send_motion(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_motion(32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send_motion(32'h80000000, 32'h7FFFFFFF, 32'h01000000);
    send_motion(32'h7FFFFFFF, 32'h80000000, 32'h00800000);
    send_motion(32'h00010000, 32'h00030000, 32'h01000000);
    send_motion(32'hFFFF0000, 32'h00010000, 32'hFFFFFFFF);
    write_reg(CFG_RADIUS, 32'hFFFFFFFF);
    write_reg(CFG_SEP, 32'h1);
    // large steps push both axes into saturation and wrap the heading
    send_motion(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_motion(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_motion(32'h00001000, 32'h00003000, 32'h00400000);
    send_motion(32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send_motion(32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send_motion(32'h00020000, 32'h00010000, 32'h01000000);
    write_reg(CFG_SEP, 32'h0);
    send_motion(32'h00050000, 32'h00050000, 32'h01000000);
    send_motion(32'h00010000, 32'h00020000, 32'h00100000);
    send_motion(32'h00020000, 32'h00010000, 32'h00100000);
    write_reg(CFG_RADIUS, 32'h0);
    send_motion(32'h00010000, 32'h00020000, 32'h00100000);
    write_reg(CFG_SEP, 32'hFFFFFFFF);
    write_reg(CFG_RADIUS, RADIUS_RST);
    send_motion(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);

    send_idle_pct = 31;
    recv_idle_pct = 79;
    write_reg(CFG_SEP, SEP_RST);
    run_phase(260);
    hold_req = hold_req + 1;
    run_phase(20);
    drain_results();
    run_phase(260);

    send_idle_pct = 79;
    recv_idle_pct = 31;
    write_reg(CFG_RADIUS, $urandom_range(1, 32'h00100000));
    write_reg(CFG_SEP, $urandom_range(1, 32'h00100000));
    run_phase(540);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_RADIUS, $urandom);
    write_reg(CFG_SEP, $urandom);
    run_phase(270);
    write_reg(CFG_RADIUS, 32'h00008000);
    write_reg(CFG_SEP, 32'h00000001);
    run_phase(270);

    drain_results();
    repeat (100) @(posedge clk);
    if (odo_sb.errors == 0 && odo_sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
